@@ design/http_response_header_parser_top_assert.svh @@
// assertion macros for the http response header parser back end
// expects clk and rst_n in the including module scope
`ifndef HTTP_RESPONSE_HEADER_PARSER_TOP_ASSERT_SVH
`define HTTP_RESPONSE_HEADER_PARSER_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define HRHP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define HRHP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/hrhp_pkg.sv @@
// shared types, constants and keyword helpers for the http response header parser
// no dependencies
package hrhp_pkg;

    localparam int unsigned HDR_W    = 17;
    localparam int unsigned BODY_W   = 20;
    localparam int unsigned CFG_W    = 20;
    localparam int unsigned STATUS_W = 10;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned KEY_W    = 17 * 8;

    localparam logic [HDR_W-1:0]  MAX_HDR_RESET  = HDR_W'(16 << 10);
    localparam logic [BODY_W-1:0] MAX_BODY_RESET = BODY_W'(64 << 10);

    typedef enum logic [0:0] {
        CFG_MAX_HEADER,
        CFG_MAX_BODY
    } cfg_index_t;

    typedef enum logic [2:0] {
        RES_OK,
        RES_BAD_RESPONSE,
        RES_BAD_STATUS,
        RES_BAD_LENGTH,
        RES_BAD_ENCODING,
        RES_NO_LENGTH,
        RES_TOO_LARGE
    } code_t;

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_SEEK_SPACE,
        PH_DIGITS,
        PH_STATUS_REST,
        PH_NAME,
        PH_VALUE,
        PH_BODY,
        PH_DONE
    } phase_t;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [POS_W-1:0] POS_MAX    = 5'd31;
    localparam logic [POS_W-1:0] LEN_PREFIX = 5'd5;
    localparam logic [POS_W-1:0] LEN_CLEN   = 5'd14;
    localparam logic [POS_W-1:0] LEN_CONN   = 5'd10;
    localparam logic [POS_W-1:0] LEN_TE     = 5'd17;
    localparam logic [POS_W-1:0] LEN_CLOSE  = 5'd5;
    localparam logic [POS_W-1:0] LEN_IDENT  = 5'd8;

    localparam logic [KEY_W-1:0] KEY_PREFIX = "HTTP/";
    localparam logic [KEY_W-1:0] KEY_CLEN   = "content-length";
    localparam logic [KEY_W-1:0] KEY_CONN   = "connection";
    localparam logic [KEY_W-1:0] KEY_TE     = "transfer-encoding";
    localparam logic [KEY_W-1:0] KEY_CLOSE  = "close";
    localparam logic [KEY_W-1:0] KEY_IDENT  = "identity";

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        code_t               result_code;
        logic [STATUS_W-1:0] status_code;
        logic                close_connection;
        logic [BODY_W-1:0]   body_length;
    } result_t;

    typedef struct packed {
        logic [7:0] data;
        logic [7:0] lower;
        logic       is_digit;
        logic       is_ws;
        logic       is_space;
        logic       is_colon;
    } char_t;

    typedef struct packed {
        logic  abandon;
        logic  is_cr;
        logic  is_lf;
        char_t ch;
    } token_t;

    localparam char_t CR_CLASS = '{data: CH_CR, lower: CH_CR, is_digit: 1'b0,
                                   is_ws: 1'b0, is_space: 1'b0, is_colon: 1'b0};

    // keyword character at pos, left to right, strings stored right aligned
    function automatic logic key_match(logic [KEY_W-1:0] key, logic [POS_W-1:0] len,
                                       logic [POS_W-1:0] pos, logic [7:0] c);
        logic [POS_W-1:0] idx;
        idx = len - pos - POS_W'(1);
        return (pos < len) && (key[{idx, 3'b000} +: 8] == c);
    endfunction

endpackage

@@ design/hrhp_queue.sv @@
// small flip-flop queue, depth a power of two
// no dependencies
module hrhp_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ design/hrhp_front.sv @@
// front end: classifies incoming bytes into tokens and queues them
// depends on hrhp_pkg and hrhp_queue
module hrhp_front #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  hrhp_pkg::item_t       item,
    output logic                  full,
    output logic                  tok_valid,
    output hrhp_pkg::token_t      tok,
    input  logic                  tok_take
);

    localparam int unsigned TOK_W = $bits(hrhp_pkg::token_t);

    hrhp_pkg::token_t   tok_in;
    logic [TOK_W-1:0]   tok_bits;
    logic               tok_empty;
    logic [7:0]         c;

    assign c = item.data_byte;

    always_comb
    begin
        tok_in.abandon     = item.action;
        tok_in.is_cr       = (c == hrhp_pkg::CH_CR);
        tok_in.is_lf       = (c == hrhp_pkg::CH_LF);
        tok_in.ch.data     = c;
        tok_in.ch.lower    = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
        tok_in.ch.is_digit = (c >= 8'h30 && c <= 8'h39);
        tok_in.ch.is_space = (c == hrhp_pkg::CH_SPACE);
        tok_in.ch.is_ws    = (c == hrhp_pkg::CH_SPACE) || (c == hrhp_pkg::CH_TAB);
        tok_in.ch.is_colon = (c == hrhp_pkg::CH_COLON);
    end

    hrhp_queue #(
        .WIDTH (TOK_W),
        .DEPTH (DEPTH)
    ) u_tok_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (tok_in),
        .full  (full),
        .pop   (tok_take),
        .rdata (tok_bits),
        .empty (tok_empty)
    );

    assign tok_valid = !tok_empty;
    assign tok       = hrhp_pkg::token_t'(tok_bits);

endmodule

@@ design/hrhp_back.sv @@
// back end: response parser state, configuration registers and result generation
// depends on hrhp_pkg and the assertion macro header
`include "http_response_header_parser_top_assert.svh"

module hrhp_back #(
    parameter int unsigned LENGTH_WIDTH = 20
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  hrhp_pkg::cfg_index_t            cfg_index,
    input  logic [hrhp_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            tok_valid,
    input  hrhp_pkg::token_t                tok,
    output logic                            tok_take,
    input  logic                            res_ready,
    output logic                            res_push,
    output hrhp_pkg::result_t               res
);

    localparam int unsigned AW = LENGTH_WIDTH + 1;
    localparam int unsigned CW =
        ((LENGTH_WIDTH > hrhp_pkg::BODY_W) ? LENGTH_WIDTH : hrhp_pkg::BODY_W) + 5;
    localparam logic [CW-1:0] LEN_CAP = (CW'(1) << LENGTH_WIDTH) - CW'(1);

    typedef struct packed {
        hrhp_pkg::phase_t                phase;
        logic [hrhp_pkg::HDR_W-1:0]      hdr_count;
        logic [hrhp_pkg::POS_W-1:0]      line_pos;
        logic [2:0]                      name_cand;
        logic [1:0]                      value_cand;
        logic                            value_started;
        logic [1:0]                      term;
        logic [hrhp_pkg::STATUS_W-1:0]   status;
        logic [AW-1:0]                   len_acc;
        logic                            len_seen;
        logic                            close_seen;
        hrhp_pkg::code_t                 first_error;
        logic [LENGTH_WIDTH-1:0]         body_rem;
    } parse_t;

    localparam parse_t PARSE_CLEAR = '{
        phase:         hrhp_pkg::PH_PREFIX,
        hdr_count:     '0,
        line_pos:      '0,
        name_cand:     3'b111,
        value_cand:    2'b11,
        value_started: 1'b0,
        term:          2'b00,
        status:        '0,
        len_acc:       '0,
        len_seen:      1'b0,
        close_seen:    1'b0,
        first_error:   hrhp_pkg::RES_OK,
        body_rem:      '0
    };

    logic [hrhp_pkg::HDR_W-1:0]  max_hdr_reg;
    logic [hrhp_pkg::BODY_W-1:0] max_body_reg;
    logic [CW-1:0]               len_limit;
    parse_t                      st_reg;
    parse_t                      st_next;

    function automatic parse_t content_byte(parse_t s, hrhp_pkg::char_t ch, logic [CW-1:0] lim);
        parse_t        r;
        logic [CW-1:0] wide;
        logic [2:0]    kept;
        logic          kw_ok;
        r = s;
        if (r.first_error == hrhp_pkg::RES_OK)
        begin
            case (r.phase)
                hrhp_pkg::PH_PREFIX:
                begin
                    if (hrhp_pkg::key_match(hrhp_pkg::KEY_PREFIX, hrhp_pkg::LEN_PREFIX,
                                            r.line_pos, ch.data))
                    begin
                        r.line_pos = r.line_pos + hrhp_pkg::POS_W'(1);
                        if (r.line_pos == hrhp_pkg::LEN_PREFIX)
                        begin
                            r.phase = hrhp_pkg::PH_SEEK_SPACE;
                        end
                    end
                    else
                    begin
                        r.first_error = hrhp_pkg::RES_BAD_RESPONSE;
                    end
                end
                hrhp_pkg::PH_SEEK_SPACE:
                begin
                    if (ch.is_space)
                    begin
                        r.phase    = hrhp_pkg::PH_DIGITS;
                        r.line_pos = '0;
                        r.status   = '0;
                    end
                end
                hrhp_pkg::PH_DIGITS:
                begin
                    if (ch.is_digit)
                    begin
                        r.status = r.status * hrhp_pkg::STATUS_W'(10)
                                 + hrhp_pkg::STATUS_W'(ch.data[3:0]);
                        r.line_pos = r.line_pos + hrhp_pkg::POS_W'(1);
                        if (r.line_pos >= hrhp_pkg::POS_W'(3))
                        begin
                            r.phase = hrhp_pkg::PH_STATUS_REST;
                        end
                    end
                    else
                    begin
                        r.first_error = hrhp_pkg::RES_BAD_STATUS;
                    end
                end
                hrhp_pkg::PH_NAME:
                begin
                    if (ch.is_colon)
                    begin
                        kept[0] = r.name_cand[0] && (r.line_pos == hrhp_pkg::LEN_CLEN);
                        kept[1] = r.name_cand[1] && (r.line_pos == hrhp_pkg::LEN_CONN);
                        kept[2] = r.name_cand[2] && (r.line_pos == hrhp_pkg::LEN_TE);
                        r.name_cand     = kept;
                        r.phase         = hrhp_pkg::PH_VALUE;
                        r.line_pos      = '0;
                        r.value_started = 1'b0;
                        r.value_cand    = 2'b11;
                        r.len_acc       = '0;
                    end
                    else
                    begin
                        if (!hrhp_pkg::key_match(hrhp_pkg::KEY_CLEN, hrhp_pkg::LEN_CLEN,
                                                 r.line_pos, ch.lower))
                        begin
                            r.name_cand[0] = 1'b0;
                        end
                        if (!hrhp_pkg::key_match(hrhp_pkg::KEY_CONN, hrhp_pkg::LEN_CONN,
                                                 r.line_pos, ch.lower))
                        begin
                            r.name_cand[1] = 1'b0;
                        end
                        if (!hrhp_pkg::key_match(hrhp_pkg::KEY_TE, hrhp_pkg::LEN_TE,
                                                 r.line_pos, ch.lower))
                        begin
                            r.name_cand[2] = 1'b0;
                        end
                        if (r.line_pos != hrhp_pkg::POS_MAX)
                        begin
                            r.line_pos = r.line_pos + hrhp_pkg::POS_W'(1);
                        end
                    end
                end
                hrhp_pkg::PH_VALUE:
                begin
                    // leading blanks are dropped
                    if (r.value_started || !ch.is_ws)
                    begin
                        r.value_started = 1'b1;
                        if (r.name_cand[1])
                        begin
                            kw_ok = hrhp_pkg::key_match(hrhp_pkg::KEY_CLOSE, hrhp_pkg::LEN_CLOSE,
                                                        r.line_pos, ch.lower);
                        end
                        else if (r.name_cand[2])
                        begin
                            kw_ok = hrhp_pkg::key_match(hrhp_pkg::KEY_IDENT, hrhp_pkg::LEN_IDENT,
                                                        r.line_pos, ch.lower);
                        end
                        else
                        begin
                            kw_ok = 1'b0;
                        end
                        if (!kw_ok)
                        begin
                            r.value_cand[0] = 1'b0;
                        end
                        if (ch.is_digit && r.value_cand[1])
                        begin
                            wide = CW'(r.len_acc) * CW'(10) + CW'(ch.data[3:0]);
                            // saturate just above the limit
                            if (wide > lim)
                            begin
                                r.len_acc = AW'(lim + CW'(1));
                            end
                            else
                            begin
                                r.len_acc = AW'(wide);
                            end
                        end
                        else
                        begin
                            r.value_cand[1] = 1'b0;
                        end
                        if (r.line_pos != hrhp_pkg::POS_MAX)
                        begin
                            r.line_pos = r.line_pos + hrhp_pkg::POS_W'(1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        return r;
    endfunction

    function automatic parse_t line_end(parse_t s, logic [CW-1:0] lim);
        parse_t r;
        r = s;
        if (r.first_error == hrhp_pkg::RES_OK)
        begin
            case (r.phase)
                hrhp_pkg::PH_PREFIX:
                begin
                    r.first_error = hrhp_pkg::RES_BAD_RESPONSE;
                end
                hrhp_pkg::PH_SEEK_SPACE, hrhp_pkg::PH_DIGITS:
                begin
                    r.first_error = hrhp_pkg::RES_BAD_STATUS;
                end
                hrhp_pkg::PH_VALUE:
                begin
                    if (r.name_cand[0])
                    begin
                        if (!r.value_started || !r.value_cand[1] || (CW'(r.len_acc) > lim))
                        begin
                            r.first_error = hrhp_pkg::RES_BAD_LENGTH;
                        end
                        else
                        begin
                            r.len_seen = 1'b1;
                            r.body_rem = LENGTH_WIDTH'(r.len_acc);
                        end
                    end
                    else if (r.name_cand[1])
                    begin
                        if (r.value_started && r.value_cand[0]
                            && (r.line_pos == hrhp_pkg::LEN_CLOSE))
                        begin
                            r.close_seen = 1'b1;
                        end
                    end
                    else if (r.name_cand[2])
                    begin
                        if (!(r.value_started && r.value_cand[0]
                              && (r.line_pos == hrhp_pkg::LEN_IDENT)))
                        begin
                            r.first_error = hrhp_pkg::RES_BAD_ENCODING;
                        end
                    end
                    r.phase     = hrhp_pkg::PH_NAME;
                    r.line_pos  = '0;
                    r.name_cand = 3'b111;
                end
                default:
                begin
                    r.phase     = hrhp_pkg::PH_NAME;
                    r.line_pos  = '0;
                    r.name_cand = 3'b111;
                end
            endcase
        end
        return r;
    endfunction

    assign len_limit = (CW'(max_body_reg) < LEN_CAP) ? CW'(max_body_reg) : LEN_CAP;
    assign tok_take  = tok_valid && res_ready;

    always_comb
    begin
        parse_t        s;
        logic          was_cr;
        logic          done;
        logic [CW-1:0] len_wide;
        s        = st_reg;
        was_cr   = st_reg.term[0];
        done     = 1'b0;
        len_wide = CW'(st_reg.len_acc);
        st_next  = st_reg;
        res_push = 1'b0;
        res      = '0;
        if (tok_take)
        begin
            if (tok.abandon)
            begin
                st_next = PARSE_CLEAR;
            end
            else if (st_reg.phase == hrhp_pkg::PH_BODY)
            begin
                if (s.body_rem != '0)
                begin
                    s.body_rem = s.body_rem - LENGTH_WIDTH'(1);
                end
                if (s.body_rem == '0)
                begin
                    res_push             = 1'b1;
                    res.result_code      = hrhp_pkg::RES_OK;
                    res.status_code      = s.status;
                    res.close_connection = s.close_seen;
                    res.body_length      = len_wide[hrhp_pkg::BODY_W-1:0];
                    s.phase              = hrhp_pkg::PH_DONE;
                end
                st_next = s;
            end
            else if (st_reg.phase != hrhp_pkg::PH_DONE)
            begin
                s.hdr_count = s.hdr_count + hrhp_pkg::HDR_W'(1);
                if (tok.is_lf && was_cr)
                begin
                    s = line_end(s, len_limit);
                end
                else
                begin
                    // a cr that was held back is ordinary content
                    if (was_cr)
                    begin
                        s = content_byte(s, hrhp_pkg::CR_CLASS, len_limit);
                    end
                    if (!tok.is_cr)
                    begin
                        s = content_byte(s, tok.ch, len_limit);
                    end
                end
                if (tok.is_cr)
                begin
                    s.term = (st_reg.term == 2'd2) ? 2'd3 : 2'd1;
                end
                else if (tok.is_lf)
                begin
                    if (st_reg.term == 2'd3)
                    begin
                        done   = 1'b1;
                        s.term = 2'd0;
                    end
                    else
                    begin
                        s.term = (st_reg.term == 2'd1) ? 2'd2 : 2'd0;
                    end
                end
                else
                begin
                    s.term = 2'd0;
                end
                if (done)
                begin
                    if (s.first_error != hrhp_pkg::RES_OK)
                    begin
                        res_push        = 1'b1;
                        res.result_code = s.first_error;
                        s.phase         = hrhp_pkg::PH_DONE;
                    end
                    else if (!s.len_seen)
                    begin
                        res_push        = 1'b1;
                        res.result_code = hrhp_pkg::RES_NO_LENGTH;
                        s.phase         = hrhp_pkg::PH_DONE;
                    end
                    else if (s.body_rem == '0)
                    begin
                        res_push             = 1'b1;
                        res.result_code      = hrhp_pkg::RES_OK;
                        res.status_code      = s.status;
                        res.close_connection = s.close_seen;
                        s.phase              = hrhp_pkg::PH_DONE;
                    end
                    else
                    begin
                        s.len_acc = AW'(s.body_rem);
                        s.phase   = hrhp_pkg::PH_BODY;
                    end
                end
                else if (s.hdr_count >= max_hdr_reg)
                begin
                    res_push        = 1'b1;
                    res.result_code = hrhp_pkg::RES_TOO_LARGE;
                    s.phase         = hrhp_pkg::PH_DONE;
                end
                st_next = s;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= PARSE_CLEAR;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_hdr_reg  <= hrhp_pkg::MAX_HDR_RESET;
            max_body_reg <= hrhp_pkg::MAX_BODY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hrhp_pkg::CFG_MAX_HEADER: max_hdr_reg  <= cfg_data[hrhp_pkg::HDR_W-1:0];
                hrhp_pkg::CFG_MAX_BODY:   max_body_reg <= cfg_data[hrhp_pkg::BODY_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    `HRHP_ASSERT_IMPLY(a_result_has_room, res_push, res_ready && tok_take, "result without room or token")
    `HRHP_ASSERT_NEXT(a_done_after_result, res_push, st_reg.phase == hrhp_pkg::PH_DONE, "no done after result")
    `HRHP_ASSERT_IMPLY(a_body_pending, st_reg.phase == hrhp_pkg::PH_BODY, st_reg.body_rem != '0, "body phase with nothing left")

endmodule

@@ design/http_response_header_parser_top.sv @@
// http/1.1 response header parser
// channels: item queue (push/full), result queue (empty/pop), config write port
// each accepted item is one response byte (action 0) or an abandon (action 1)
// that resets the response state and gives no result
// one result per response: at body end, at header end on an error, a missing length or zero
// length, or at once when the header byte count reaches max_header_bytes
// throughput: one item per cycle while the result queue has room, set by the combinational parser step in the back end
// a result shows on the result ports once the byte that causes it has passed through
// the token queue and the result has been written into the result queue
// stall: the result queue holds two results; when it is full the parser waits,
// the four-entry token queue fills and full rises, no transaction is lost
// reset: both queues empty, parser at the start of a status line,
// max_header_bytes = 16384, max_body_bytes = 65536
// configuration writes are taken at once on any edge with cfg_we high
// depends on hrhp_pkg, hrhp_queue, hrhp_front and hrhp_back
module http_response_header_parser_top #(
    parameter int unsigned LENGTH_WIDTH = 20,
    parameter int unsigned TOKEN_DEPTH  = 4,
    parameter int unsigned RESULT_DEPTH = 2
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  hrhp_pkg::cfg_index_t        cfg_index,
    input  logic [hrhp_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        push,
    input  hrhp_pkg::item_t             item,
    output logic                        full,
    output logic                        empty,
    input  logic                        pop,
    output hrhp_pkg::result_t           result
);

    localparam int unsigned RES_W = $bits(hrhp_pkg::result_t);

    logic               tok_valid;
    hrhp_pkg::token_t   tok;
    logic               tok_take;
    logic               res_full;
    logic               res_push;
    hrhp_pkg::result_t  res;
    logic [RES_W-1:0]   res_bits;

    hrhp_front #(
        .DEPTH (TOKEN_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_take  (tok_take)
    );

    hrhp_back #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_take  (tok_take),
        .res_ready (!res_full),
        .res_push  (res_push),
        .res       (res)
    );

    hrhp_queue #(
        .WIDTH (RES_W),
        .DEPTH (RESULT_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_bits),
        .empty (empty)
    );

    assign result = hrhp_pkg::result_t'(res_bits);

endmodule
